// ===== rtl/core/hrc_pkg.sv =====
package hrc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COEF_N    = 8;
	localparam int IDX_W     = $clog2(COEF_N);
	localparam int ADDR_W    = IDX_W + 2;
	localparam int DATA_W    = 32;
	localparam int COST_W    = 48;
	localparam int MUL_W     = 48;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int PRJ_W     = 60;
	localparam int LIN_W     = 66;
	localparam int DIV_CAP_W = 40;
	localparam int QUO_W     = DIV_CAP_W + 1;
	localparam int NUM_W     = 64 + FRAC_BITS;
	localparam int DEN_W     = 64;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = RAD_W / 2;

	localparam logic REQ_POINT = 1'b0;
	localparam logic REQ_LINE  = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic [IDX_W-1:0] REG_H00 = 3'd0;
	localparam logic [IDX_W-1:0] REG_H01 = 3'd1;
	localparam logic [IDX_W-1:0] REG_H02 = 3'd2;
	localparam logic [IDX_W-1:0] REG_H10 = 3'd3;
	localparam logic [IDX_W-1:0] REG_H11 = 3'd4;
	localparam logic [IDX_W-1:0] REG_H12 = 3'd5;
	localparam logic [IDX_W-1:0] REG_H20 = 3'd6;
	localparam logic [IDX_W-1:0] REG_H21 = 3'd7;

	localparam logic signed [DATA_W-1:0] COEF_ONE = 32'sd16777216;

	typedef struct packed {
		logic                     req_type;
		logic signed [DATA_W-1:0] src_x;
		logic signed [DATA_W-1:0] src_y;
		logic signed [DATA_W-1:0] dst_first;
		logic signed [DATA_W-1:0] dst_second;
		logic signed [DATA_W-1:0] line_offset;
		logic                     last_of_set;
	} hrc_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] residual_first;
		logic signed [DATA_W-1:0] residual_second;
		logic        [COST_W-1:0] cost_total;
		logic                     cost_final;
		logic                     status;
	} hrc_rsp_t;

	function automatic logic signed [DATA_W-1:0] coef_reset(input logic [IDX_W-1:0] idx);
		logic signed [DATA_W-1:0] val;
		val = '0;
		if (idx == REG_H00 || idx == REG_H11) begin
			val = COEF_ONE;
		end
		return val;
	endfunction

endpackage

// ===== rtl/core/hrc_mul.sv =====
module hrc_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hrc_pkg::MUL_W-1:0]   a,
	input  logic [hrc_pkg::MUL_W-1:0]   b,
	output logic                        done,
	output logic [hrc_pkg::PROD_W-1:0]  prod
);
	import hrc_pkg::*;

	localparam int CNT_W = $clog2(MUL_W);

	logic [MUL_W-1:0]  a_q;
	logic [PROD_W-1:0] acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_W:0]    hi_sum;

	// One multiplier bit per cycle: add the multiplicand to the upper half, then shift right.
	assign hi_sum = {1'b0, acc_q[PROD_W-1:MUL_W]} + (acc_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= {hi_sum, acc_q[MUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// ===== rtl/core/hrc_div.sv =====
module hrc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hrc_pkg::NUM_W-1:0]   num,
	input  logic [hrc_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [hrc_pkg::QUO_W-1:0]   quo
);
	import hrc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [QUO_W-1:0] CAP = {1'b1, {DIV_CAP_W{1'b0}}};

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	// Quotients at or above the cap all report the cap.
	assign quo  = (ovf_q || quo_q[QUO_W-1]) ? CAP : quo_q;
	assign done = done_q;
endmodule

// ===== rtl/core/hrc_sqrt.sv =====
module hrc_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hrc_pkg::RAD_W-1:0]   rad,
	output logic                        done,
	output logic [hrc_pkg::ROOT_W-1:0]  root
);
	import hrc_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  trial_rem;
	logic [REM_W+1:0]  trial;
	logic              ge;
	logic [REM_W+1:0]  diff;

	// Digit-by-digit square root, two radicand bits per cycle.
	assign trial_rem = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign ge        = trial_rem >= trial;
	assign diff      = trial_rem - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : trial_rem[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

// ===== rtl/core/homography_residual_cost.sv =====
// Words are handled one at a time: a new word is taken only in the idle step, which the
// sequencer reaches once the last word has gone from the done step into a free output register.
// A zero denominator or a degenerate line ends a word early, before any division. The shared
// bit-serial multiplier, restoring divider and square root are used in turn by one sequencer.
// Reset sets the coefficients to the identity, clears the cost sum and empties the output register.
module homography_residual_cost (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hrc_pkg::ADDR_W-1:0]  paddr,
	input  logic [hrc_pkg::DATA_W-1:0]  pwdata,
	output logic [hrc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  hrc_pkg::hrc_req_t           req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output hrc_pkg::hrc_rsp_t           rsp
);
	import hrc_pkg::*;

	// Sequencer steps. Each step other than idle and done issues one job to a unit and folds the
	// unit's answer into the datapath when it finishes; ST_DIVU of a degenerate word issues none.
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_PX0   = 5'd1;
	localparam logic [4:0] ST_PX1   = 5'd2;
	localparam logic [4:0] ST_PY0   = 5'd3;
	localparam logic [4:0] ST_PY1   = 5'd4;
	localparam logic [4:0] ST_PW0   = 5'd5;
	localparam logic [4:0] ST_PW1   = 5'd6;
	localparam logic [4:0] ST_DIVU  = 5'd7;
	localparam logic [4:0] ST_DIVV  = 5'd8;
	localparam logic [4:0] ST_DXX   = 5'd9;
	localparam logic [4:0] ST_DYY   = 5'd10;
	localparam logic [4:0] ST_LPU   = 5'd11;
	localparam logic [4:0] ST_LQV   = 5'd12;
	localparam logic [4:0] ST_LPP   = 5'd13;
	localparam logic [4:0] ST_LQQ   = 5'd14;
	localparam logic [4:0] ST_SQRT  = 5'd15;
	localparam logic [4:0] ST_LDIST = 5'd16;
	localparam logic [4:0] ST_LDD   = 5'd17;
	localparam logic [4:0] ST_DONE  = 5'd18;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
	localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

	// Configuration registers.
	logic signed [DATA_W-1:0] coef_q [COEF_N];

	// Sequencer and datapath registers.
	logic [4:0]               step_q;
	logic                     issue_q;
	hrc_req_t                 req_q;
	logic signed [PRJ_W-1:0]  nx_q;
	logic signed [PRJ_W-1:0]  ny_q;
	logic signed [PRJ_W-1:0]  w_q;
	logic signed [DATA_W-1:0] u_q;
	logic signed [DATA_W-1:0] v_q;
	logic signed [LIN_W-1:0]  s_q;
	logic [RAD_W-1:0]         n2_q;
	logic [ROOT_W-1:0]        root_q;
	logic [QUO_W-1:0]         dist_q;
	logic signed [DATA_W-1:0] r1_q;
	logic signed [DATA_W-1:0] r2_q;
	logic                     status_q;
	logic [COST_W-1:0]        acc_q;
	logic                     rsp_valid_q;
	hrc_rsp_t                 rsp_q;

	// Unit connections.
	logic                     mul_start;
	logic                     mul_done;
	logic [MUL_W-1:0]         mul_a;
	logic [MUL_W-1:0]         mul_b;
	logic [PROD_W-1:0]        mul_prod;
	logic                     div_start;
	logic                     div_done;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic [QUO_W-1:0]         div_quo;
	logic                     sqrt_start;
	logic                     sqrt_done;
	logic [ROOT_W-1:0]        sqrt_root;

	// Datapath logic.
	logic signed [MUL_W-1:0]  opa;
	logic signed [MUL_W-1:0]  opb;
	logic                     mul_neg_q;
	logic signed [PROD_W:0]   prod_s;
	logic signed [PRJ_W-1:0]  prj_add;
	logic signed [LIN_W-1:0]  lin_add;
	logic [PROD_W-1:0]        prod_scaled;
	logic [COST_W-1:0]        sq_add;
	logic [COST_W:0]          acc_sum;
	logic [COST_W-1:0]        acc_next;
	logic signed [DATA_W:0]   dx;
	logic signed [DATA_W:0]   dy;
	logic [PRJ_W-1:0]         nx_mag;
	logic [PRJ_W-1:0]         ny_mag;
	logic [PRJ_W-1:0]         w_mag;
	logic [LIN_W-1:0]         s_mag;
	logic                     degenerate;
	logic                     is_mul_step;
	logic                     req_fire;
	logic                     rsp_load;

	function automatic logic signed [DATA_W-1:0] sat_quo(input logic [QUO_W-1:0] q,
		input logic neg);
		logic signed [QUO_W:0] sq;
		sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (sq > $signed({{(QUO_W-DATA_W+1){1'b0}}, POS_MAX})) begin
			return POS_MAX;
		end else if (sq < $signed({{(QUO_W-DATA_W+1){1'b1}}, NEG_MAX})) begin
			return NEG_MAX;
		end
		return sq[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_diff(input logic signed [DATA_W:0] d);
		if (d[DATA_W] != d[DATA_W-1]) begin
			return d[DATA_W] ? NEG_MAX : POS_MAX;
		end
		return d[DATA_W-1:0];
	endfunction

	// APB register file. Writes are expected only while the block is idle.
	assign pready = 1'b1;
	assign prdata = coef_q[paddr[ADDR_W-1:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_N; i++) begin
				coef_q[i] <= coef_reset(IDX_W'(i));
			end
		end else if (psel && penable && pwrite) begin
			coef_q[paddr[ADDR_W-1:2]] <= pwdata;
		end
	end

	assign req_ready = (step_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_load  = (step_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// Residuals against the target point, formed one bit wider than the fields.
	assign dx = {u_q[DATA_W-1], u_q} - {req_q.dst_first[DATA_W-1], req_q.dst_first};
	assign dy = {v_q[DATA_W-1], v_q} - {req_q.dst_second[DATA_W-1], req_q.dst_second};

	assign nx_mag = nx_q[PRJ_W-1] ? PRJ_W'(-nx_q) : PRJ_W'(nx_q);
	assign ny_mag = ny_q[PRJ_W-1] ? PRJ_W'(-ny_q) : PRJ_W'(ny_q);
	assign w_mag  = w_q[PRJ_W-1] ? PRJ_W'(-w_q) : PRJ_W'(w_q);
	assign s_mag  = s_q[LIN_W-1] ? LIN_W'(-s_q) : LIN_W'(s_q);

	// A zero denominator fails both item kinds; a line with a and b both zero has no normal.
	assign degenerate = (w_q == '0) || ((req_q.req_type == REQ_LINE) &&
		(req_q.dst_first == '0) && (req_q.dst_second == '0));

	// Operand selection for the shared multiplier. Signed operands go in as magnitudes and
	// the sign of the product is restored afterwards.
	always_comb begin
		opa = '0;
		opb = '0;
		is_mul_step = 1'b1;
		case (step_q)
			ST_PX0: begin
				opa = MUL_W'(coef_q[REG_H00]);
				opb = MUL_W'(req_q.src_x);
			end
			ST_PX1: begin
				opa = MUL_W'(coef_q[REG_H01]);
				opb = MUL_W'(req_q.src_y);
			end
			ST_PY0: begin
				opa = MUL_W'(coef_q[REG_H10]);
				opb = MUL_W'(req_q.src_x);
			end
			ST_PY1: begin
				opa = MUL_W'(coef_q[REG_H11]);
				opb = MUL_W'(req_q.src_y);
			end
			ST_PW0: begin
				opa = MUL_W'(coef_q[REG_H20]);
				opb = MUL_W'(req_q.src_x);
			end
			ST_PW1: begin
				opa = MUL_W'(coef_q[REG_H21]);
				opb = MUL_W'(req_q.src_y);
			end
			ST_DXX: begin
				opa = MUL_W'(dx);
				opb = MUL_W'(dx);
			end
			ST_DYY: begin
				opa = MUL_W'(dy);
				opb = MUL_W'(dy);
			end
			ST_LPU: begin
				opa = MUL_W'(req_q.dst_first);
				opb = MUL_W'(u_q);
			end
			ST_LQV: begin
				opa = MUL_W'(req_q.dst_second);
				opb = MUL_W'(v_q);
			end
			ST_LPP: begin
				opa = MUL_W'(req_q.dst_first);
				opb = MUL_W'(req_q.dst_first);
			end
			ST_LQQ: begin
				opa = MUL_W'(req_q.dst_second);
				opb = MUL_W'(req_q.dst_second);
			end
			ST_LDD: begin
				opa = MUL_W'({1'b0, dist_q});
				opb = MUL_W'({1'b0, dist_q});
			end
			default: begin
				is_mul_step = 1'b0;
			end
		endcase
	end

	assign mul_a     = opa[MUL_W-1] ? MUL_W'(-opa) : MUL_W'(opa);
	assign mul_b     = opb[MUL_W-1] ? MUL_W'(-opb) : MUL_W'(opb);
	assign mul_start = issue_q && is_mul_step;

	always_comb begin
		div_num = '0;
		div_den = '0;
		case (step_q)
			ST_DIVU: begin
				div_num = NUM_W'(nx_mag) << FRAC_BITS;
				div_den = DEN_W'(w_mag);
			end
			ST_DIVV: begin
				div_num = NUM_W'(ny_mag) << FRAC_BITS;
				div_den = DEN_W'(w_mag);
			end
			ST_LDIST: begin
				div_num = NUM_W'(s_mag) << 2;
				div_den = DEN_W'(root_q);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	assign div_start  = issue_q && (((step_q == ST_DIVU) && !degenerate) ||
		(step_q == ST_DIVV) || (step_q == ST_LDIST));
	assign sqrt_start = issue_q && (step_q == ST_SQRT);

	// Signed product and the scaled terms that the sums take from it.
	assign prod_s  = mul_neg_q ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
	assign prj_add = PRJ_W'(prod_s >>> 8);
	assign lin_add = LIN_W'(prod_s >>> 2);

	// Squared residual scaled back to the fraction format, saturated to the cost width.
	assign prod_scaled = mul_prod >> FRAC_BITS;
	assign sq_add   = (|prod_scaled[PROD_W-1:COST_W]) ? COST_MAX : prod_scaled[COST_W-1:0];
	assign acc_sum  = {1'b0, acc_q} + {1'b0, sq_add};
	assign acc_next = acc_sum[COST_W] ? COST_MAX : acc_sum[COST_W-1:0];

	hrc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	hrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	hrc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (n2_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// Sequencer. Control state and the cost sum are reset; datapath registers are not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			issue_q     <= 1'b0;
			acc_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The output register fills from the done step and empties when taken.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (mul_start) begin
				mul_neg_q <= opa[MUL_W-1] ^ opb[MUL_W-1];
			end
			case (step_q)
				ST_IDLE: begin
					if (req_fire) begin
						req_q    <= req;
						nx_q     <= PRJ_W'(coef_q[REG_H02]) <<< (FRAC_BITS - 8);
						ny_q     <= PRJ_W'(coef_q[REG_H12]) <<< (FRAC_BITS - 8);
						w_q      <= PRJ_W'(1) << (16 + FRAC_BITS);
						s_q      <= LIN_W'(req.line_offset) <<< (FRAC_BITS - 2);
						r1_q     <= '0;
						r2_q     <= '0;
						status_q <= STATUS_OK;
						step_q   <= ST_PX0;
						issue_q  <= 1'b1;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						rsp_q.residual_first  <= r1_q;
						rsp_q.residual_second <= r2_q;
						rsp_q.cost_total      <= acc_q;
						rsp_q.cost_final      <= req_q.last_of_set;
						rsp_q.status          <= status_q;
						if (req_q.last_of_set) begin
							acc_q <= '0;
						end
						step_q <= ST_IDLE;
					end
				end
				default: begin
					if (issue_q) begin
						issue_q <= 1'b0;
						if ((step_q == ST_DIVU) && degenerate) begin
							status_q <= STATUS_BAD;
							step_q   <= ST_DONE;
						end
					end else if (mul_done || div_done || sqrt_done) begin
						// The last job of either word kind leads to the done step,
						// which issues nothing.
						issue_q <= (step_q != ST_DYY) && (step_q != ST_LDD);
						case (step_q)
							ST_PX0: begin
								nx_q   <= nx_q + prj_add;
								step_q <= ST_PX1;
							end
							ST_PX1: begin
								nx_q   <= nx_q + prj_add;
								step_q <= ST_PY0;
							end
							ST_PY0: begin
								ny_q   <= ny_q + prj_add;
								step_q <= ST_PY1;
							end
							ST_PY1: begin
								ny_q   <= ny_q + prj_add;
								step_q <= ST_PW0;
							end
							ST_PW0: begin
								w_q    <= w_q + prj_add;
								step_q <= ST_PW1;
							end
							ST_PW1: begin
								w_q    <= w_q + prj_add;
								step_q <= ST_DIVU;
							end
							ST_DIVU: begin
								u_q    <= sat_quo(div_quo, nx_q[PRJ_W-1] ^ w_q[PRJ_W-1]);
								step_q <= ST_DIVV;
							end
							ST_DIVV: begin
								v_q    <= sat_quo(div_quo, ny_q[PRJ_W-1] ^ w_q[PRJ_W-1]);
								step_q <= (req_q.req_type == REQ_LINE) ? ST_LPU : ST_DXX;
							end
							ST_DXX: begin
								acc_q  <= acc_next;
								r1_q   <= sat_diff(dx);
								step_q <= ST_DYY;
							end
							ST_DYY: begin
								acc_q  <= acc_next;
								r2_q   <= sat_diff(dy);
								step_q <= ST_DONE;
							end
							ST_LPU: begin
								s_q    <= s_q + lin_add;
								step_q <= ST_LQV;
							end
							ST_LQV: begin
								s_q    <= s_q + lin_add;
								step_q <= ST_LPP;
							end
							ST_LPP: begin
								n2_q   <= mul_prod[RAD_W-1:0];
								step_q <= ST_LQQ;
							end
							ST_LQQ: begin
								n2_q   <= n2_q + mul_prod[RAD_W-1:0];
								step_q <= ST_SQRT;
							end
							ST_SQRT: begin
								root_q <= sqrt_root;
								step_q <= ST_LDIST;
							end
							ST_LDIST: begin
								dist_q <= div_quo;
								step_q <= ST_LDD;
							end
							ST_LDD: begin
								acc_q  <= acc_next;
								r1_q   <= (dist_q > QUO_W'(POS_MAX)) ? POS_MAX :
									DATA_W'(dist_q);
								step_q <= ST_DONE;
							end
							default: begin
								step_q <= ST_IDLE;
							end
						endcase
					end
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only one arithmetic unit is started at a time.
	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_start, div_start, sqrt_start}))
		else $error("more than one unit started in a cycle");

	// An accepted word always leaves the idle step.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (step_q == ST_PX0) && issue_q)
		else $error("accepted word did not start the sequencer");

	// The sum is cleared once the last word of a set has been reported.
	a_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && req_q.last_of_set) |=> (acc_q == '0) && rsp_valid_q)
		else $error("cost sum not cleared at end of set");

	// A failed word reports zero residuals.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.status == STATUS_BAD)) |->
		(rsp_q.residual_first == '0) && (rsp_q.residual_second == '0))
		else $error("failed word carries nonzero residuals");
endmodule
